FILE: rtl/core/nsq_pkg.sv
// Shared types and constants for the Newton square root pipeline.
// No dependencies.
`timescale 1ns / 1ps
package nsq_pkg;
   localparam int OperandWidth = 32;
   localparam int RootWidth    = 24;
   localparam int MsbWidth     = 5;

   // control that travels with every beat through the pipeline
   typedef struct packed {
      logic valid;
      logic zero;
   } ctl_type;

   // position of the highest set bit; 0 for an all-zero word
   function automatic logic [MsbWidth-1:0] lead_one(input logic [OperandWidth-1:0] v);
      logic [MsbWidth-1:0] pos;
      pos = '0;
      for (int i = 0; i < OperandWidth; i++) begin
         if (v[i]) begin
            pos = MsbWidth'(i);
         end
      end
      return pos;
   endfunction
endpackage

FILE: rtl/core/nsq_req_if.sv
// Request channel interface: valid/ready with the signed Q16.16 operand.
// Depends on nsq_pkg.
`timescale 1ns / 1ps
interface nsq_req_if;
   logic valid;
   logic ready;
   logic signed [nsq_pkg::OperandWidth-1:0] operand_value;
   modport source (output valid, output operand_value, input ready);
   modport sink (input valid, input operand_value, output ready);
endinterface

FILE: rtl/core/nsq_rsp_if.sv
// Response channel interface: valid/ready with the unsigned root estimate.
// Depends on nsq_pkg.
`timescale 1ns / 1ps
interface nsq_rsp_if;
   logic valid;
   logic ready;
   logic [nsq_pkg::RootWidth-1:0] root_value;
   modport source (output valid, output root_value, input ready);
   modport sink (input valid, input root_value, output ready);
endinterface

FILE: rtl/core/nsq_front.sv
// Front stage: sign/zero check, leading-one search and seed estimate.
// Depends on nsq_pkg.
`timescale 1ns / 1ps
module nsq_front #(
   parameter int FRACTION_BITS = 16,
   parameter int DW = 31 + FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  logic [nsq_pkg::OperandWidth-1:0]    operand,
   output nsq_pkg::ctl_type                    ctl_out,
   output logic [DW-1:0]                       num_out,
   output logic [DW-1:0]                       est_out
);
   nsq_pkg::ctl_type ctl_ff, ctl_in;
   logic [DW-1:0] num_ff, num_in, est_ff, est_in;
   logic [nsq_pkg::MsbWidth-1:0] msb;
   logic [nsq_pkg::MsbWidth:0] shamt;

   always_comb begin
      msb = nsq_pkg::lead_one(operand);
      shamt = ({1'b0, msb} + (nsq_pkg::MsbWidth+1)'(FRACTION_BITS)) >> 1;
      ctl_in.valid = in_valid;
      ctl_in.zero = (operand == '0) || operand[nsq_pkg::OperandWidth-1];
      num_in = DW'(operand[nsq_pkg::OperandWidth-2:0]) << FRACTION_BITS;
      // a dummy seed of one keeps the divisor nonzero for dropped operands
      est_in = ctl_in.zero ? DW'(1) : (DW'(1) << shamt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= num_in;
         est_ff <= est_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign num_out = num_ff;
   assign est_out = est_ff;
endmodule

FILE: rtl/core/nsq_newton.sv
// One Newton step: restoring divide, one quotient bit per stage, then average.
// Depends on nsq_pkg.
`timescale 1ns / 1ps
module nsq_newton #(
   parameter int FRACTION_BITS = 16,
   parameter int DW = 31 + FRACTION_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  nsq_pkg::ctl_type  ctl_inp,
   input  logic [DW-1:0]     num_inp,
   input  logic [DW-1:0]     est_inp,
   output nsq_pkg::ctl_type  ctl_out,
   output logic [DW-1:0]     num_out,
   output logic [DW-1:0]     est_out
);
   nsq_pkg::ctl_type ctl_ff [0:DW];
   logic [DW-1:0] num_ff [0:DW];
   logic [DW-1:0] est_ff [0:DW];
   logic [DW-1:0] rem_ff [0:DW];
   logic [DW-1:0] quo_ff [0:DW];
   nsq_pkg::ctl_type ctl_last_ff;
   logic [DW-1:0] num_last_ff, est_last_ff, est_last_in;

   assign ctl_ff[0] = ctl_inp;
   assign num_ff[0] = num_inp;
   assign est_ff[0] = est_inp;
   assign rem_ff[0] = '0;
   assign quo_ff[0] = '0;

   for (genvar k = 0; k < DW; k++) begin : g_div
      logic [DW:0] trial;
      logic [DW-1:0] rem_in, quo_in;
      logic fits;

      always_comb begin
         trial = {rem_ff[k], num_ff[k][DW-1-k]};
         fits = trial >= {1'b0, est_ff[k]};
         rem_in = fits ? DW'(trial - {1'b0, est_ff[k]}) : trial[DW-1:0];
         quo_in = {quo_ff[k][DW-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k+1] <= '0;
         end else if (adv) begin
            ctl_ff[k+1] <= ctl_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            num_ff[k+1] <= num_ff[k];
            est_ff[k+1] <= est_ff[k];
            rem_ff[k+1] <= rem_in;
            quo_ff[k+1] <= quo_in;
         end
      end
   end

   assign est_last_in = DW'(({1'b0, est_ff[DW]} + {1'b0, quo_ff[DW]}) >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_last_ff <= '0;
      end else if (adv) begin
         ctl_last_ff <= ctl_ff[DW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_last_ff <= num_ff[DW];
         est_last_ff <= est_last_in;
      end
   end

   assign ctl_out = ctl_last_ff;
   assign num_out = num_last_ff;
   assign est_out = est_last_ff;
endmodule

FILE: rtl/core/fixed_point_newton_sqrt.sv
// Top level of the Newton square root pipeline for signed Q16.16 operands.
// Depends on nsq_pkg, nsq_req_if, nsq_rsp_if, nsq_front and nsq_newton.
//
//   channel  dir  beat payload
//   req_ch   in   operand_value : signed 32-bit Q16.16
//   rsp_ch   out  root_value    : unsigned 24-bit Q8.16 root estimate
//
// One beat enters per cycle while the pipeline advances. The stages are one
// front stage, then per Newton step one stage per quotient bit of
// the (31 + FRACTION_BITS)-bit restoring divide plus one averaging stage.
// Reset clears every stage valid bit; payload registers are not reset.
// The whole pipeline advances as one: it holds when the output beat is
// valid and not taken, so a stall drops and repeats nothing.
`timescale 1ns / 1ps
module fixed_point_newton_sqrt #(
   parameter int NEWTON_STEPS  = 4,
   parameter int FRACTION_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   nsq_req_if.sink   req_ch,
   nsq_rsp_if.source rsp_ch
);
   localparam int DW = 31 + FRACTION_BITS;

   nsq_pkg::ctl_type ctl_chain [0:NEWTON_STEPS];
   logic [DW-1:0] num_chain [0:NEWTON_STEPS];
   logic [DW-1:0] est_chain [0:NEWTON_STEPS];
   logic adv;

   // advance whenever the output register is empty or being drained
   assign adv = !ctl_chain[NEWTON_STEPS].valid || rsp_ch.ready;
   assign req_ch.ready = adv;

   nsq_front #(.FRACTION_BITS(FRACTION_BITS), .DW(DW)) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_ch.valid),
      .operand  (req_ch.operand_value),
      .ctl_out  (ctl_chain[0]),
      .num_out  (num_chain[0]),
      .est_out  (est_chain[0])
   );

   // one divide-and-average unit per Newton step
   for (genvar s = 0; s < NEWTON_STEPS; s++) begin : g_step
      nsq_newton #(.FRACTION_BITS(FRACTION_BITS), .DW(DW)) u_newton (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .ctl_inp (ctl_chain[s]),
         .num_inp (num_chain[s]),
         .est_inp (est_chain[s]),
         .ctl_out (ctl_chain[s+1]),
         .num_out (num_chain[s+1]),
         .est_out (est_chain[s+1])
      );
   end

   // drop the estimate for zero or negative operands
   assign rsp_ch.valid = ctl_chain[NEWTON_STEPS].valid;
   assign rsp_ch.root_value = ctl_chain[NEWTON_STEPS].zero ? '0
                            : est_chain[NEWTON_STEPS][nsq_pkg::RootWidth-1:0];

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("output valid right after reset");
   a_hold_front: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(ctl_chain[0]))
      else $error("front stage moved during a stall");
   a_zero_root: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && ctl_chain[NEWTON_STEPS].zero) |-> rsp_ch.root_value == '0)
      else $error("dropped operand gave a nonzero root");
   a_seed_nonzero: assert property (@(posedge clock) disable iff (reset)
      ctl_chain[0].valid |-> est_chain[0] != '0)
      else $error("zero divisor entered the divide");
endmodule
